// ----- sv/tdtg_pkg.sv -----
// ----------------------------------------------------------------------------
// tdtg_pkg: shared definitions for the tick-driven tone generator
// Holds the default sizes, register indexes and the output bundle type.
// ----------------------------------------------------------------------------
package tdtg_pkg;

  localparam int unsigned TickBitsDef       = 32;
  localparam int unsigned DirectionLimitDef = 50;

  // Width of the configured period and of the half period fed to the divider.
  localparam int unsigned PeriodWidth = 32;
  // The direction counter is six bits wide, so the limit stays below 64.
  localparam int unsigned CountWidth  = 6;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CFG_MODE   = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_PERIOD = 1'b1;

  // Operating modes.
  localparam logic MODE_STEPPER = 1'b0;
  localparam logic MODE_BRIDGE  = 1'b1;

  // One result item, last field in the lowest bit.
  typedef struct packed {
    logic toggled;
    logic secondary_driven;
    logic secondary_level;
    logic primary_driven;
    logic primary_level;
  } tdtg_result_t;

  localparam int unsigned ResultBits = $bits(tdtg_result_t);
  localparam int unsigned ResultData = ((ResultBits + 7) / 8) * 8;

endpackage

// ----- sv/tdtg_divider.sv -----
// ----------------------------------------------------------------------------
// tdtg_divider: iterative restoring divider
// Produces the quotient of an unsigned dividend by a nonzero 32-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdtg_divider #(
  parameter int unsigned DividendBits = tdtg_pkg::TickBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DividendBits-1:0]          dividend_i,
  input  logic [tdtg_pkg::PeriodWidth-1:0] divisor_i,
  output logic                             done_o,
  output logic [DividendBits-1:0]          quotient_o
);
  import tdtg_pkg::*;

  localparam int unsigned CntWidth = $clog2(DividendBits + 1);

  logic [CntWidth-1:0]     cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [DividendBits-1:0] quo_q, quo_d;
  logic [PeriodWidth-1:0]  rem_q, rem_d;
  logic [PeriodWidth-1:0]  div_q, div_d;
  logic [PeriodWidth:0]    shifted;
  logic [PeriodWidth:0]    diff;
  logic                    ge;

  // The quotient register starts with the dividend and shifts quotient bits
  // in from the bottom as dividend bits leave at the top.
  assign shifted = {rem_q, quo_q[DividendBits-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = CntWidth'(DividendBits);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      quo_d  = {quo_q[DividendBits-2:0], ge};
      rem_d  = ge ? diff[PeriodWidth-1:0] : shifted[PeriodWidth-1:0];
      done_d = (cnt_q == CntWidth'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/tick_driven_tone_generator.sv -----
// ----------------------------------------------------------------------------
// tick_driven_tone_generator: square-wave tone generator driven by timer ticks
// Toggles a step or bridge output whenever a tick enters a new half period.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the s_axis channel carries one timer tick value. For
// each tick the block returns exactly one transaction on the m_axis channel
// with the pin levels, the drive enables and a flag telling whether this
// tick toggled the wave. Mode and period are written through the cfg port;
// the user must write them only while the block is idle, which the block
// does not enforce. A period of 0 stops the wave. A tick with a nonzero
// period takes two passes of the shared bit-serial divider, one for the
// new tick and one for the tick of the last toggle; with period 0 no
// divider pass is made. The input is not ready while a tick is being
// worked on, so a new tick is taken only once the last one has finished.
// A finished result waits in the output register; if the receiver stalls,
// the next tick is still accepted and processed, and it then waits until
// the output register frees up.
// Reset clears both registers, the wave, the direction and the counter,
// and leaves the output channel empty.
// ----------------------------------------------------------------------------
module tick_driven_tone_generator #(
  parameter int unsigned TICK_BITS       = tdtg_pkg::TickBitsDef,
  parameter int unsigned DIRECTION_LIMIT = tdtg_pkg::DirectionLimitDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [tdtg_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [tdtg_pkg::PeriodWidth-1:0]   cfg_data_i,
  // Tick input; tdata holds tick.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((TICK_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Result output; tdata holds primary_level, primary_driven,
  // secondary_level, secondary_driven, toggled, then zero padding.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tdtg_pkg::ResultData-1:0]    m_axis_tdata
);
  import tdtg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_TICK,
    ST_DIV_LAST,
    ST_FINISH
  } state_e;

  state_e                 state_q, state_d;
  logic                   mode_q, mode_d;
  logic [PeriodWidth-1:0] period_q, period_d;
  logic [TICK_BITS-1:0]   last_tick_q, last_tick_d;
  logic                   wave_q, wave_d;
  logic                   dir_q, dir_d;
  logic [CountWidth-1:0]  count_q, count_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic [TICK_BITS-1:0]   quo_tick_q, quo_tick_d;
  logic                   toggle_q, toggle_d;
  logic                   out_valid_q, out_valid_d;
  tdtg_result_t           result_q, result_d;

  logic [PeriodWidth-1:0] half;
  logic                   div_start;
  logic [TICK_BITS-1:0]   div_dividend;
  logic                   div_done;
  logic [TICK_BITS-1:0]   div_quotient;

  // Half period, with a half period of zero treated as one.
  always_comb begin
    half = {1'b0, period_q[PeriodWidth-1:1]};
    if (half == '0) begin
      half = PeriodWidth'(1);
    end
  end

  tdtg_divider #(
    .DividendBits(TICK_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (half),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    period_d     = period_q;
    last_tick_d  = last_tick_q;
    wave_d       = wave_q;
    dir_d        = dir_q;
    count_d      = count_q;
    tick_d       = tick_q;
    quo_tick_d   = quo_tick_q;
    toggle_d     = toggle_q;
    out_valid_d  = out_valid_q;
    result_d     = result_q;
    div_start    = 1'b0;
    div_dividend = tick_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_d   = cfg_data_i[0];
        CFG_PERIOD: period_d = cfg_data_i;
        default:    ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          tick_d   = s_axis_tdata[TICK_BITS-1:0];
          toggle_d = 1'b0;
          if (period_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            div_start    = 1'b1;
            div_dividend = s_axis_tdata[TICK_BITS-1:0];
            state_d      = ST_DIV_TICK;
          end
        end
      end
      ST_DIV_TICK: begin
        if (div_done) begin
          quo_tick_d   = div_quotient;
          div_start    = 1'b1;
          div_dividend = last_tick_q;
          state_d      = ST_DIV_LAST;
        end
      end
      ST_DIV_LAST: begin
        if (div_done) begin
          toggle_d = (div_quotient != quo_tick_q);
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          if (toggle_q) begin
            if (mode_q == MODE_STEPPER) begin
              if (count_q >= CountWidth'(DIRECTION_LIMIT)) begin
                count_d = '0;
                dir_d   = ~dir_q;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            wave_d      = ~wave_q;
            last_tick_d = tick_q;
          end
          result_d.toggled = toggle_q;
          if (mode_q == MODE_STEPPER) begin
            result_d.primary_level    = wave_d;
            result_d.primary_driven   = ~wave_d;
            result_d.secondary_level  = dir_d;
            result_d.secondary_driven = ~dir_d;
          end else if (period_q == '0) begin
            result_d.primary_level    = 1'b0;
            result_d.primary_driven   = 1'b1;
            result_d.secondary_level  = 1'b0;
            result_d.secondary_driven = 1'b1;
          end else begin
            result_d.primary_level    = wave_d;
            result_d.primary_driven   = 1'b1;
            result_d.secondary_level  = ~wave_d;
            result_d.secondary_driven = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      period_q    <= '0;
      last_tick_q <= '0;
      wave_q      <= 1'b0;
      dir_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      period_q    <= period_d;
      last_tick_q <= last_tick_d;
      wave_q      <= wave_d;
      dir_q       <= dir_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    quo_tick_q <= quo_tick_d;
    toggle_q   <= toggle_d;
    result_q   <= result_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ResultData'(result_q);

endmodule

// ----- test/tick_driven_tone_generator_tb.sv -----
// ----------------------------------------------------------------------------
// tick_driven_tone_generator_tb: self-checking bench for the tone generator
// Feeds timer ticks in bursts under several mode and period settings, runs a
// cycle-free model of the wave, direction and counter state beside the block,
// and compares every result transaction field by field with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tick_driven_tone_generator_tb;
  import tdtg_pkg::*;

  localparam int unsigned TickData     = ((TickBitsDef + 7) / 8) * 8;
  localparam int unsigned TailCycles   = 2 * TickBitsDef + 3 + 20;
  localparam int unsigned WatchdogSpan = 4000;
  localparam int unsigned RandomTicks  = 1600;

  typedef enum logic [1:0] {
    STIM_TICK,
    STIM_CFG,
    STIM_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e             kind;
    logic [CfgIdxWidth-1:0] idx;
    logic [PeriodWidth-1:0] value;
  } stim_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i     = '0;
  logic [PeriodWidth-1:0] cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TickData-1:0]    s_axis_tdata  = '0;  // tick
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // primary_level, primary_driven, secondary_level, secondary_driven, toggled
  logic [ResultData-1:0]  m_axis_tdata;

  tick_driven_tone_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predicted tone generator state and configuration.
  logic                   tone_mode      = MODE_STEPPER;
  logic [PeriodWidth-1:0] tone_period    = '0;
  logic [TickBitsDef-1:0] last_edge_tick = '0;
  logic                   wave_lvl       = 1'b0;
  logic                   dir_lvl        = 1'b0;
  logic [CountWidth-1:0]  dir_count      = '0;

  stim_t        pending_stim[$];
  tdtg_result_t expected_pins[$];
  int           planned_ticks  = 0;
  int           pins_issued    = 0;
  int           pins_checked   = 0;
  int           mismatch_count = 0;

  function automatic tdtg_result_t advance_tone(input logic [TickBitsDef-1:0] tick);
    tdtg_result_t           pins;
    logic [PeriodWidth-1:0] half;
    pins = '0;
    half = tone_period >> 1;
    if (half == '0) begin
      half = 1;
    end
    if (tone_period != '0 && (tick / half) != (last_edge_tick / half)) begin
      if (tone_mode == MODE_STEPPER) begin
        if (dir_count >= DirectionLimitDef) begin
          dir_count = '0;
          dir_lvl   = ~dir_lvl;
        end else begin
          dir_count = dir_count + 1'b1;
        end
      end
      wave_lvl       = ~wave_lvl;
      last_edge_tick = tick;
      pins.toggled   = 1'b1;
    end
    if (tone_mode == MODE_STEPPER) begin
      // Open-drain pins: a high level is released rather than driven.
      pins.primary_level    = wave_lvl;
      pins.primary_driven   = ~wave_lvl;
      pins.secondary_level  = dir_lvl;
      pins.secondary_driven = ~dir_lvl;
    end else if (tone_period == '0) begin
      pins.primary_driven   = 1'b1;
      pins.secondary_driven = 1'b1;
    end else begin
      pins.primary_level    = wave_lvl;
      pins.primary_driven   = 1'b1;
      pins.secondary_level  = ~wave_lvl;
      pins.secondary_driven = 1'b1;
    end
    return pins;
  endfunction

  function automatic void push_tick(input logic [TickBitsDef-1:0] tick);
    stim_t s;
    s.kind  = STIM_TICK;
    s.idx   = '0;
    s.value = tick;
    pending_stim.push_back(s);
    planned_ticks++;
  endfunction

  function automatic void push_cfg(input logic [CfgIdxWidth-1:0] idx,
                                   input logic [PeriodWidth-1:0] value);
    stim_t s;
    s.kind  = STIM_CFG;
    s.idx   = idx;
    s.value = value;
    pending_stim.push_back(s);
  endfunction

  function automatic void push_drain();
    stim_t s;
    s.kind  = STIM_DRAIN;
    s.idx   = '0;
    s.value = '0;
    pending_stim.push_back(s);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: ticks go out in bursts; register writes and drains wait until
  // every result in flight has come back.
  int                     gap_left;
  int                     burst_left;
  int                     in_flight;
  int                     issued_n;
  logic                   vld_n;
  logic [TickData-1:0]    tick_n;
  logic                   we_n;
  logic [CfgIdxWidth-1:0] idx_n;
  logic [PeriodWidth-1:0] cfg_n;
  stim_t                  head;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_we_i      <= 1'b0;
      cfg_idx_i     <= '0;
      cfg_data_i    <= '0;
      pins_issued   <= 0;
      gap_left      = 0;
      burst_left    = 1;
    end else begin
      vld_n     = s_axis_tvalid;
      tick_n    = s_axis_tdata;
      we_n      = 1'b0;
      idx_n     = cfg_idx_i;
      cfg_n     = cfg_data_i;
      issued_n  = pins_issued;
      in_flight = pins_issued - pins_checked;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pins.push_back(advance_tone(s_axis_tdata[TickBitsDef-1:0]));
        issued_n++;
        in_flight++;
        vld_n = 1'b0;
      end
      if (!vld_n && pending_stim.size() > 0) begin
        head = pending_stim[0];
        case (head.kind)
          STIM_TICK: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              vld_n  = 1'b1;
              tick_n = head.value;
              void'(pending_stim.pop_front());
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
              end
            end
          end
          STIM_CFG: begin
            if (in_flight == 0) begin
              we_n  = 1'b1;
              idx_n = head.idx;
              cfg_n = head.value;
              if (head.idx == CFG_MODE) begin
                tone_mode = head.value[0];
              end else begin
                tone_period = head.value;
              end
              void'(pending_stim.pop_front());
            end
          end
          default: begin
            if (in_flight == 0) begin
              void'(pending_stim.pop_front());
            end
          end
        endcase
      end
      s_axis_tvalid <= vld_n;
      s_axis_tdata  <= tick_n;
      cfg_we_i      <= we_n;
      cfg_idx_i     <= idx_n;
      cfg_data_i    <= cfg_n;
      pins_issued   <= issued_n;
    end
  end

  // Monitor: the receiver alternates between open stretches and stalls of
  // short or long length.
  int           hold_left;
  tdtg_result_t got_pins;
  tdtg_result_t want_pins;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pins_checked  <= 0;
      hold_left     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pins_checked == pins_issued) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata), '0);
        end else begin
          want_pins = expected_pins.pop_front();
          got_pins  = tdtg_result_t'(m_axis_tdata[ResultBits-1:0]);
          pins_checked <= pins_checked + 1;
          if (got_pins.primary_level !== want_pins.primary_level)
            report_mismatch("primary_level", 32'(got_pins.primary_level),
                            32'(want_pins.primary_level));
          if (got_pins.primary_driven !== want_pins.primary_driven)
            report_mismatch("primary_driven", 32'(got_pins.primary_driven),
                            32'(want_pins.primary_driven));
          if (got_pins.secondary_level !== want_pins.secondary_level)
            report_mismatch("secondary_level", 32'(got_pins.secondary_level),
                            32'(want_pins.secondary_level));
          if (got_pins.secondary_driven !== want_pins.secondary_driven)
            report_mismatch("secondary_driven", 32'(got_pins.secondary_driven),
                            32'(want_pins.secondary_driven));
          if (got_pins.toggled !== want_pins.toggled)
            report_mismatch("toggled", 32'(got_pins.toggled),
                            32'(want_pins.toggled));
          if (m_axis_tdata[ResultData-1:ResultBits] !== '0)
            report_mismatch("padding", 32'(m_axis_tdata[ResultData-1:ResultBits]), '0);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if ($urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        hold_left = $urandom_range(1, 150);
      end else begin
        m_axis_tready <= 1'b0;
        hold_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 100);
      end
    end
  end

  // Watchdog on cycles without any transaction or register write.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogSpan) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Period in force once a phase's writes are done; only used to size the
  // timer steps, so a skipped period write keeps the last planned period.
  logic [PeriodWidth-1:0] planned_period = '0;

  function automatic logic [PeriodWidth-1:0] tone_period_after(
      input logic [PeriodWidth-1:0] per, input int pick);
    if (pick != 1) begin
      planned_period = per;
    end
    return planned_period;
  endfunction

  initial begin
    int                     phase_len;
    int                     pick;
    logic [PeriodWidth-1:0] per;
    logic [TickBitsDef-1:0] timer_now;

    // Stopped after reset: pins report the reset states.
    push_tick('0);
    push_tick('1);
    // Stopped bridge drives both outputs low.
    push_cfg(CFG_MODE, PeriodWidth'(MODE_BRIDGE));
    push_tick(32'h1234_5678);
    // Period one: the half period is clamped, so any change of tick toggles.
    push_cfg(CFG_PERIOD, 1);
    push_tick(1);
    push_tick(1);
    push_tick(2);
    push_tick('1);
    push_tick('0);
    // Largest period, buckets around the top of the tick range.
    push_cfg(CFG_PERIOD, '1);
    push_tick(32'h7FFF_FFFE);
    push_tick(32'h7FFF_FFFF);
    push_tick(32'hFFFF_FFFD);
    push_tick(32'hFFFF_FFFE);
    push_tick(32'hFFFF_FFFF);
    // Mode change keeps the shared state.
    push_cfg(CFG_MODE, PeriodWidth'(MODE_STEPPER));
    push_tick('0);
    push_tick(32'h8000_0000);
    push_cfg(CFG_PERIOD, 2);
    push_tick(1);
    push_tick(2);
    push_tick(3);
    push_cfg(CFG_PERIOD, 0);
    push_tick(32'h5555_5555);
    push_tick(32'hAAAA_AAAA);
    push_drain();

    // Random phases: mostly a free-running timer stepping by up to one period
    // (by up to 2 below period 2), with some arbitrary ticks and drains mixed in.
    timer_now = $urandom;
    while (planned_ticks < RandomTicks + 23) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0:       per = '0;
        1:       per = 1;
        2:       per = '1;
        3:       per = 32'h8000_0000;
        4:       per = $urandom;
        5:       per = $urandom_range(2, 3);
        default: per = $urandom_range(4, 64);
      endcase
      pick = $urandom_range(0, 3);
      if (pick != 2) begin
        push_cfg(CFG_MODE,
                 PeriodWidth'(($urandom_range(0, 2) == 0) ? MODE_BRIDGE : MODE_STEPPER));
      end
      if (pick != 1) begin
        push_cfg(CFG_PERIOD, per);
      end
      per = tone_period_after(per, pick);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
          push_drain();
        end else if (pick < 4) begin
          push_tick($urandom);
        end else begin
          timer_now = timer_now + ((per > 1) ? $urandom_range(0, per) : $urandom_range(0, 2));
          push_tick(timer_now);
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending_stim.size() != 0 || s_axis_tvalid || pins_issued != pins_checked)
      @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
